// File: src/tgw_pkg.sv
// Shared types, codes and neighbour helpers for the tile grid wall block.
// Used by every module under src except tgw_ram; depends on nothing else.
package tgw_pkg;

  localparam int GRID_ROWS_DEF = 64;
  localparam int GRID_COLS_DEF = 64;
  localparam int COORD_W       = 9;
  localparam int QUEUE_DEPTH   = 2;
  localparam int WORD_W        = 7;

  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_SET    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [1:0] KIND_DONE   = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_ENTRY  = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [2:0] TILE_SPACE = 3'd0;
  localparam logic [2:0] TILE_WALL  = 3'd1;

  typedef enum logic [2:0] {
    OP_WRITE, OP_SET, OP_REMOVE, OP_QUERY, OP_REJECT
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD_TGT, ST_NB_RD, ST_NB_UPD, ST_TGT_WR,
    ST_FINISH, ST_Q_RD, ST_Q_CAP, ST_Q_EMIT
  } st_e;

  typedef struct packed {
    op_e                op;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [2:0]         tile;
  } cmd_t;

  // Directions 0..7: up, right, down, left, up-right, right-down,
  // down-left, left-up. A step below zero wraps to a large value.
  function automatic logic [COORD_W-1:0] nb_row(logic [COORD_W-1:0] r, logic [2:0] k);
    logic [COORD_W-1:0] res;
    case (k)
      3'd0, 3'd4, 3'd7: res = r - COORD_W'(1);
      3'd2, 3'd5, 3'd6: res = r + COORD_W'(1);
      default:          res = r;
    endcase
    return res;
  endfunction

  function automatic logic [COORD_W-1:0] nb_col(logic [COORD_W-1:0] c, logic [2:0] k);
    logic [COORD_W-1:0] res;
    case (k)
      3'd1, 3'd4, 3'd5: res = c + COORD_W'(1);
      3'd3, 3'd6, 3'd7: res = c - COORD_W'(1);
      default:          res = c;
    endcase
    return res;
  endfunction

endpackage

// File: src/tgw_ram.sv
// Generic single-port RAM with a registered read.
// Stand-alone; no package needed.
module tgw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/tgw_front.sv
// Front end: accepts commands, checks positions and classifies operations.
// Depends on tgw_pkg.
module tgw_front #(
  parameter int GRID_ROWS = tgw_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = tgw_pkg::GRID_COLS_DEF
) (
  input  logic          start_i,
  input  logic [1:0]    action_i,
  input  logic [5:0]    col_i,
  input  logic [5:0]    row_i,
  input  logic [2:0]    tile_type_i,
  input  logic          q_full_i,
  input  logic          clearing_i,
  output logic          busy_o,
  output logic          push_o,
  output tgw_pkg::cmd_t cmd_o
);

  logic in_grid, interior;

  always_comb begin
    in_grid  = (int'(row_i) < GRID_ROWS) && (int'(col_i) < GRID_COLS);
    interior = (row_i != 6'd0) && (col_i != 6'd0) &&
               (int'(row_i) <= GRID_ROWS - 2) && (int'(col_i) <= GRID_COLS - 2);
    busy_o   = q_full_i | clearing_i;
    push_o   = start_i & ~busy_o;
    cmd_o.row  = tgw_pkg::COORD_W'(row_i);
    cmd_o.col  = tgw_pkg::COORD_W'(col_i);
    cmd_o.tile = tile_type_i;
    if (!in_grid) begin
      cmd_o.op = tgw_pkg::OP_REJECT;
    end else begin
      case (action_i)
        tgw_pkg::ACT_WRITE:  cmd_o.op = tgw_pkg::OP_WRITE;
        tgw_pkg::ACT_SET:    cmd_o.op = interior ? tgw_pkg::OP_SET : tgw_pkg::OP_REJECT;
        tgw_pkg::ACT_REMOVE: cmd_o.op = interior ? tgw_pkg::OP_REMOVE : tgw_pkg::OP_REJECT;
        default:             cmd_o.op = tgw_pkg::OP_QUERY;
      endcase
    end
  end

endmodule

// File: src/tgw_queue.sv
// Short command queue between the front end and the back end.
// Depends on tgw_pkg.
module tgw_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tgw_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output tgw_pkg::cmd_t cmd_o,
  output logic          empty_o,
  output logic          full_o
);

  localparam int PW = $clog2(tgw_pkg::QUEUE_DEPTH);

  tgw_pkg::cmd_t   slot_q [tgw_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]     cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? wr_q + PW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + PW'(1) : rd_q;
    cnt_d = cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  assign cmd_o   = slot_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (PW+1)'(tgw_pkg::QUEUE_DEPTH));

endmodule

// File: src/tgw_back.sv
// Back end: sequencer that clears the grid after reset, then carries out
// queued commands against the grid RAM and drives the result registers.
// Depends on tgw_pkg and tgw_ram.
module tgw_back #(
  parameter int GRID_ROWS = tgw_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = tgw_pkg::GRID_COLS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tgw_pkg::cmd_t q_cmd_i,
  input  logic          q_empty_i,
  output logic          pop_o,
  output logic          clearing_o,
  output logic          valid_o,
  output logic [1:0]    kind_o,
  output logic [5:0]    neighbor_col_o,
  output logic [5:0]    neighbor_row_o,
  output logic          diagonal_o,
  output logic [3:0]    cell_mask_o,
  output logic          last_o
);

  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = tgw_pkg::COORD_W;

  tgw_pkg::st_e  state_q, state_d;
  tgw_pkg::cmd_t cur_q, cur_d;
  logic [2:0]    k_q, k_d;
  logic [3:0]    m_q, m_d, omask_q, omask_d;
  logic [7:0]    found_q, found_d;
  logic          inr_q, inr_d;
  logic [AW-1:0] clr_q, clr_d;

  logic          val_d, diag_d, last_d;
  logic [1:0]    kind_d;
  logic [5:0]    ncol_d, nrow_d;
  logic [3:0]    cmask_d;
  logic          val_q, diag_q, last_q;
  logic [1:0]    kind_q;
  logic [5:0]    ncol_q, nrow_q;
  logic [3:0]    cmask_q;

  logic                      ram_we;
  logic [AW-1:0]             ram_addr, tgt_addr, nb_addr;
  logic [tgw_pkg::WORD_W-1:0] ram_wdata, ram_rdata;
  logic [2:0]                rd_tile;
  logic [3:0]                rd_mask, own, opp;
  logic [CW-1:0]             nr, nc;
  logic                      nb_in;
  logic [7:0]                eff, higher;

  tgw_ram #(.WIDTH(tgw_pkg::WORD_W), .DEPTH(CELLS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    rd_tile  = ram_rdata[6:4];
    rd_mask  = ram_rdata[3:0];
    nr       = tgw_pkg::nb_row(cur_q.row, k_q);
    nc       = tgw_pkg::nb_col(cur_q.col, k_q);
    nb_in    = (nr < CW'(GRID_ROWS)) && (nc < CW'(GRID_COLS));
    tgt_addr = AW'(int'(cur_q.row) * GRID_COLS + int'(cur_q.col));
    nb_addr  = AW'(int'(nr) * GRID_COLS + int'(nc));
    own      = 4'd1 << k_q[1:0];
    opp      = 4'd1 << (k_q[1:0] + 2'd2);
    // A diagonal counts only when both orthogonal cells beside it are open.
    eff[3:0] = found_q[3:0];
    eff[4]   = found_q[4] & found_q[0] & found_q[1];
    eff[5]   = found_q[5] & found_q[1] & found_q[2];
    eff[6]   = found_q[6] & found_q[2] & found_q[3];
    eff[7]   = found_q[7] & found_q[3] & found_q[0];
    higher   = (eff >> k_q) >> 1;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tgw_pkg::ST_CLEAR: begin
        if (clr_q == AW'(CELLS - 1)) state_d = tgw_pkg::ST_IDLE;
      end
      tgw_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          case (q_cmd_i.op)
            tgw_pkg::OP_SET, tgw_pkg::OP_REMOVE: state_d = tgw_pkg::ST_RD_TGT;
            tgw_pkg::OP_QUERY:                   state_d = tgw_pkg::ST_Q_RD;
            default:                             state_d = tgw_pkg::ST_FINISH;
          endcase
        end
      end
      tgw_pkg::ST_RD_TGT: state_d = tgw_pkg::ST_NB_RD;
      tgw_pkg::ST_NB_RD:  state_d = tgw_pkg::ST_NB_UPD;
      tgw_pkg::ST_NB_UPD: begin
        state_d = (k_q[1:0] == 2'd3) ? tgw_pkg::ST_TGT_WR : tgw_pkg::ST_NB_RD;
      end
      tgw_pkg::ST_TGT_WR: state_d = tgw_pkg::ST_FINISH;
      tgw_pkg::ST_FINISH: state_d = tgw_pkg::ST_IDLE;
      tgw_pkg::ST_Q_RD:   state_d = tgw_pkg::ST_Q_CAP;
      tgw_pkg::ST_Q_CAP: begin
        state_d = (k_q == 3'd7) ? tgw_pkg::ST_Q_EMIT : tgw_pkg::ST_Q_RD;
      end
      tgw_pkg::ST_Q_EMIT: begin
        if (eff == 8'd0 || (eff[k_q] && higher == 8'd0)) state_d = tgw_pkg::ST_IDLE;
      end
      default: state_d = tgw_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = tgt_addr;
    ram_wdata = '0;
    cur_d     = cur_q;
    k_d       = k_q;
    m_d       = m_q;
    omask_d   = omask_q;
    found_d   = found_q;
    inr_d     = inr_q;
    clr_d     = clr_q;
    val_d     = 1'b0;
    kind_d    = tgw_pkg::KIND_DONE;
    ncol_d    = '0;
    nrow_d    = '0;
    diag_d    = 1'b0;
    cmask_d   = '0;
    last_d    = 1'b0;
    case (state_q)
      tgw_pkg::ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + AW'(1);
      end
      tgw_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          cur_d   = q_cmd_i;
          k_d     = '0;
          m_d     = '0;
          found_d = '0;
        end
      end
      tgw_pkg::ST_NB_RD: begin
        ram_addr = nb_addr;
        // The target's own word arrives in the first pass.
        if (k_q[1:0] == 2'd0) omask_d = rd_mask;
      end
      tgw_pkg::ST_NB_UPD: begin
        ram_addr = nb_addr;
        if (rd_tile == tgw_pkg::TILE_WALL) begin
          ram_we = 1'b1;
          if (cur_q.op == tgw_pkg::OP_SET) begin
            ram_wdata = {rd_tile, rd_mask | opp};
            m_d       = m_q | own;
          end else begin
            ram_wdata = {rd_tile, rd_mask & ~opp};
          end
        end
        k_d = k_q + 3'd1;
      end
      tgw_pkg::ST_TGT_WR: begin
        ram_we    = 1'b1;
        ram_wdata = (cur_q.op == tgw_pkg::OP_SET) ? {tgw_pkg::TILE_WALL, m_q}
                                                  : {tgw_pkg::TILE_SPACE, omask_q};
      end
      tgw_pkg::ST_FINISH: begin
        val_d  = 1'b1;
        last_d = 1'b1;
        case (cur_q.op)
          tgw_pkg::OP_REJECT: kind_d = tgw_pkg::KIND_REJECT;
          tgw_pkg::OP_WRITE: begin
            ram_we    = 1'b1;
            ram_wdata = {cur_q.tile, 4'd0};
          end
          tgw_pkg::OP_SET: cmask_d = m_q;
          default: ;
        endcase
      end
      tgw_pkg::ST_Q_RD: begin
        ram_addr = nb_addr;
        inr_d    = nb_in;
      end
      tgw_pkg::ST_Q_CAP: begin
        found_d[k_q] = inr_q && (rd_tile == tgw_pkg::TILE_SPACE);
        k_d          = k_q + 3'd1;
      end
      tgw_pkg::ST_Q_EMIT: begin
        if (eff == 8'd0) begin
          val_d  = 1'b1;
          kind_d = tgw_pkg::KIND_NONE;
          last_d = 1'b1;
        end else if (eff[k_q]) begin
          val_d  = 1'b1;
          kind_d = tgw_pkg::KIND_ENTRY;
          ncol_d = 6'(nc);
          nrow_d = 6'(nr);
          diag_d = k_q[2];
          last_d = (higher == 8'd0);
        end
        k_d = k_q + 3'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tgw_pkg::ST_CLEAR;
      clr_q   <= '0;
      val_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      val_q   <= val_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    k_q     <= k_d;
    m_q     <= m_d;
    omask_q <= omask_d;
    found_q <= found_d;
    inr_q   <= inr_d;
    kind_q  <= kind_d;
    ncol_q  <= ncol_d;
    nrow_q  <= nrow_d;
    diag_q  <= diag_d;
    cmask_q <= cmask_d;
    last_q  <= last_d;
  end

  assign clearing_o     = (state_q == tgw_pkg::ST_CLEAR);
  assign valid_o        = val_q;
  assign kind_o         = kind_q;
  assign neighbor_col_o = ncol_q;
  assign neighbor_row_o = nrow_q;
  assign diagonal_o     = diag_q;
  assign cell_mask_o    = cmask_q;
  assign last_o         = last_q;

endmodule

// File: src/tile_grid_wall_mask_and_neighbors_top.sv
// Top level of the tile grid with wall masks and walkable-neighbour listing.
// Depends on tgw_pkg, tgw_front, tgw_queue, tgw_back and tgw_ram.
//
// Usage: drive action_i, col_i, row_i and tile_type_i with start_i high; the
// command is taken at a clock edge where busy_o is low. Results come out on
// kind_o, neighbor_col_o, neighbor_row_o, diagonal_o, cell_mask_o and last_o,
// each for exactly one cycle with valid_o high; last_o marks the final result
// of a command. The receiver cannot stall the block.
// Commands pass through a two-entry queue to a sequencer that owns the single
// port of the grid RAM, one access per cycle. Rejected positions and write_cell
// go straight to the result; set_wall and remove_wall read the target and update
// its four orthogonal neighbours; a query reads all eight neighbours, then lists
// the open ones (up to 8 results). The sequencer passes through its idle state
// between commands. The queue lets the next commands be taken while one is
// carried out. After reset the sequencer clears the grid, one cell per cycle,
// covering all GRID_ROWS*GRID_COLS cells (4096 by default); busy_o stays high meanwhile.
module tile_grid_wall_mask_and_neighbors_top #(
  parameter int GRID_ROWS = tgw_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = tgw_pkg::GRID_COLS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] action_i,
  input  logic [5:0] col_i,
  input  logic [5:0] row_i,
  input  logic [2:0] tile_type_i,
  output logic       valid_o,
  output logic [1:0] kind_o,
  output logic [5:0] neighbor_col_o,
  output logic [5:0] neighbor_row_o,
  output logic       diagonal_o,
  output logic [3:0] cell_mask_o,
  output logic       last_o
);

  tgw_pkg::cmd_t push_cmd, q_cmd;
  logic          push, pop, q_empty, q_full, clearing;

  tgw_front #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_front (
    .start_i     (start_i),
    .action_i    (action_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .tile_type_i (tile_type_i),
    .q_full_i    (q_full),
    .clearing_i  (clearing),
    .busy_o      (busy_o),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  tgw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (q_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  tgw_back #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_cmd_i        (q_cmd),
    .q_empty_i      (q_empty),
    .pop_o          (pop),
    .clearing_o     (clearing),
    .valid_o        (valid_o),
    .kind_o         (kind_o),
    .neighbor_col_o (neighbor_col_o),
    .neighbor_row_o (neighbor_row_o),
    .diagonal_o     (diagonal_o),
    .cell_mask_o    (cell_mask_o),
    .last_o         (last_o)
  );

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o != tgw_pkg::KIND_ENTRY |-> last_o)
    else $error("non-entry result without last");

  a_no_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o != tgw_pkg::KIND_ENTRY |->
      neighbor_col_o == 6'd0 && neighbor_row_o == 6'd0 && !diagonal_o)
    else $error("coordinates on a non-entry result");

  a_mask_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && cell_mask_o != 4'd0 |-> kind_o == tgw_pkg::KIND_DONE)
    else $error("mask on a result other than done");

  a_quiet_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !valid_o && !pop)
    else $error("activity during the clearing pass");

endmodule
